// ----- src/assert_macros.svh -----
// Assertion helpers used by the datapath RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LSF_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define LSF_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/lsf_pkg.sv -----
package lsf_pkg;

  localparam int LINE_BYTES  = 32;
  localparam int PATTERN_MAX = 16;

  localparam int LEN_W      = $clog2(LINE_BYTES + 1);
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int PLEN_W     = $clog2(PATTERN_MAX + 1);
  localparam int PIDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int PLEN_CFG_W = 5;
  localparam int PAT_BITS   = 128;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO  = 2'd0,
    CFG_PAT_HI  = 2'd1,
    CFG_PAT_LEN = 2'd2,
    CFG_ONLY    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRD,
    S_CCMP,
    S_ERD,
    S_ECMP,
    S_EMIT,
    S_LRD,
    S_LOUT,
    S_LNL
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic store;
    logic halt_set;
    logic eof_clear;
    logic search_init;
    logic rd;
    logic cmp_count;
    logic cmp_emit;
    logic pass_reset;
    logic emit_pat;
    logic line_out;
    logic nl_out;
    logic line_done;
  } lsf_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_eof;
    logic in_nl;
    logic halt;
    logic full;
    logic len_zero;
    logic hit;
    logic last_pos;
    logic pos_end;
    logic mcount_zero;
    logic only;
    logic out_free;
    logic emit_done;
  } lsf_sts_t;

  function automatic logic [PLEN_W-1:0] eff_len(input logic [PLEN_CFG_W-1:0] n);
    logic [PLEN_W-1:0] r;
    if (n == '0) begin
      r = PLEN_W'(1);
    end else if (32'(n) > PATTERN_MAX) begin
      r = PLEN_W'(PATTERN_MAX);
    end else begin
      r = PLEN_W'(n);
    end
    return r;
  endfunction

  function automatic logic [7:0] pat_byte(input logic [PAT_BITS-1:0] pat,
                                          input logic [PIDX_W-1:0] i);
    return pat[8*i +: 8];
  endfunction

endpackage

// ----- src/lsf_ifs.sv -----
interface lsf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink (input valid, input kind, input in_byte, output ready);
endinterface

interface lsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ----- src/lsf_ram.sv -----
module lsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/lsf_ctrl.sv -----
module lsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  lsf_pkg::lsf_sts_t st,
  output lsf_pkg::lsf_cmd_t cmd
);

  lsf_pkg::state_t state_r;
  lsf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsf_pkg::S_IDLE: begin
        if (st.in_valid && !st.in_eof && !st.halt && st.in_nl && !st.len_zero) begin
          state_nxt = lsf_pkg::S_CRD;
        end
      end
      lsf_pkg::S_CRD: state_nxt = lsf_pkg::S_CCMP;
      lsf_pkg::S_CCMP: begin
        if (st.last_pos) begin
          if (st.mcount_zero && !st.hit) begin
            state_nxt = lsf_pkg::S_IDLE;
          end else if (st.only) begin
            state_nxt = lsf_pkg::S_ERD;
          end else begin
            state_nxt = lsf_pkg::S_LRD;
          end
        end else begin
          state_nxt = lsf_pkg::S_CRD;
        end
      end
      lsf_pkg::S_ERD: state_nxt = lsf_pkg::S_ECMP;
      lsf_pkg::S_ECMP: begin
        if (st.hit) begin
          state_nxt = lsf_pkg::S_EMIT;
        end else if (st.last_pos) begin
          state_nxt = lsf_pkg::S_IDLE;
        end else begin
          state_nxt = lsf_pkg::S_ERD;
        end
      end
      lsf_pkg::S_EMIT: begin
        if (st.out_free && st.emit_done) begin
          state_nxt = st.pos_end ? lsf_pkg::S_IDLE : lsf_pkg::S_ERD;
        end
      end
      lsf_pkg::S_LRD: state_nxt = lsf_pkg::S_LOUT;
      lsf_pkg::S_LOUT: begin
        if (st.out_free) begin
          state_nxt = st.last_pos ? lsf_pkg::S_LNL : lsf_pkg::S_LRD;
        end
      end
      lsf_pkg::S_LNL: begin
        if (st.out_free) begin
          state_nxt = lsf_pkg::S_IDLE;
        end
      end
      default: state_nxt = lsf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      lsf_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          if (st.in_eof) begin
            cmd.eof_clear = 1'b1;
          end else if (!st.halt) begin
            if (!st.in_nl) begin
              cmd.halt_set = st.full;
              cmd.store    = !st.full;
            end else begin
              cmd.search_init = !st.len_zero;
            end
          end
        end
      end
      lsf_pkg::S_CRD, lsf_pkg::S_ERD, lsf_pkg::S_LRD: begin
        cmd.rd = 1'b1;
      end
      lsf_pkg::S_CCMP: begin
        cmd.cmp_count = 1'b1;
        if (st.last_pos) begin
          if (st.mcount_zero && !st.hit) begin
            cmd.line_done = 1'b1;
          end else begin
            cmd.pass_reset = 1'b1;
          end
        end
      end
      lsf_pkg::S_ECMP: begin
        cmd.cmp_emit  = 1'b1;
        cmd.line_done = !st.hit && st.last_pos;
      end
      lsf_pkg::S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_pat  = 1'b1;
          cmd.line_done = st.emit_done && st.pos_end;
        end
      end
      lsf_pkg::S_LOUT: begin
        cmd.line_out = st.out_free;
      end
      lsf_pkg::S_LNL: begin
        if (st.out_free) begin
          cmd.nl_out    = 1'b1;
          cmd.line_done = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- src/lsf_dp.sv -----
`include "assert_macros.svh"

module lsf_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  lsf_in_if.sink                             in_req,
  lsf_out_if.source                          out_rsp,
  input  logic                               cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  lsf_pkg::lsf_cmd_t                  cmd,
  output lsf_pkg::lsf_sts_t                  st
);

  localparam int LEN_W  = lsf_pkg::LEN_W;
  localparam int ADDR_W = lsf_pkg::ADDR_W;
  localparam int PLEN_W = lsf_pkg::PLEN_W;
  localparam int PIDX_W = lsf_pkg::PIDX_W;
  localparam int PM     = lsf_pkg::PATTERN_MAX;

  logic [lsf_pkg::CFG_DATA_W-1:0] pat_lo_r;
  logic [lsf_pkg::CFG_DATA_W-1:0] pat_hi_r;
  logic [lsf_pkg::PLEN_CFG_W-1:0] plen_cfg_r;
  logic                           only_r;

  logic [LEN_W-1:0]  len_r;
  logic              halt_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;

  logic [LEN_W-1:0]  pos_r;
  logic [PLEN_W-1:0] skip_r;
  logic [LEN_W-1:0]  mcount_r;
  logic [LEN_W-1:0]  occ_r;
  logic [PLEN_W-1:0] k_r;
  logic [7:0]        win_r [PM];
  logic [7:0]        pat_rev_r [PM];

  logic [lsf_pkg::PAT_BITS-1:0] pat_all;
  logic [PLEN_W-1:0]            plen;
  logic [7:0]                   rdata;
  logic [7:0]                   win_nxt [PM];
  logic [7:0]                   pat_rev_nxt [PM];
  logic                         window_eq;
  logic                         eligible;
  logic                         hit;
  logic                         cmp;
  logic                         load;
  logic                         out_free;
  logic [7:0]                   load_byte;
  logic                         load_last;

  assign pat_all  = {pat_hi_r, pat_lo_r};
  assign plen     = lsf_pkg::eff_len(plen_cfg_r);
  assign out_free = !out_valid_r || out_rsp.ready;
  assign cmp      = cmd.cmp_count || cmd.cmp_emit;
  assign load     = cmd.emit_pat || cmd.line_out || cmd.nl_out;

  lsf_ram #(
    .WIDTH(8),
    .DEPTH(lsf_pkg::LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (in_req.in_byte),
    .re    (cmd.rd),
    .raddr (pos_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    win_nxt[0] = rdata;
    for (int j = 1; j < PM; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  always_comb begin
    window_eq = 1'b1;
    for (int j = 0; j < PM; j++) begin
      if (PLEN_W'(j) < plen && win_nxt[j] != pat_rev_r[j]) begin
        window_eq = 1'b0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < PM; j++) begin
      if (PLEN_W'(j) < plen) begin
        pat_rev_nxt[j] = lsf_pkg::pat_byte(pat_all, PIDX_W'(plen - PLEN_W'(j) - PLEN_W'(1)));
      end else begin
        pat_rev_nxt[j] = 8'h00;
      end
    end
  end

  assign eligible = (skip_r == '0) &&
                    ((LEN_W+1)'(pos_r) + (LEN_W+1)'(1) >= (LEN_W+1)'(plen));
  assign hit      = eligible && window_eq;

  always_comb begin
    load_byte = rdata;
    load_last = 1'b0;
    if (cmd.emit_pat) begin
      if (k_r == plen) begin
        load_byte = lsf_pkg::NEWLINE_BYTE;
        load_last = (occ_r == mcount_r);
      end else begin
        load_byte = lsf_pkg::pat_byte(pat_all, k_r[PIDX_W-1:0]);
      end
    end else if (cmd.nl_out) begin
      load_byte = lsf_pkg::NEWLINE_BYTE;
      load_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      plen_cfg_r  <= lsf_pkg::PLEN_CFG_W'(1);
      only_r      <= 1'b0;
      len_r       <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (lsf_pkg::cfg_idx_t'(cfg_index))
          lsf_pkg::CFG_PAT_LO:  pat_lo_r   <= cfg_wdata;
          lsf_pkg::CFG_PAT_HI:  pat_hi_r   <= cfg_wdata;
          lsf_pkg::CFG_PAT_LEN: plen_cfg_r <= cfg_wdata[lsf_pkg::PLEN_CFG_W-1:0];
          lsf_pkg::CFG_ONLY:    only_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.eof_clear) begin
        len_r  <= '0;
        halt_r <= 1'b0;
      end else if (cmd.halt_set) begin
        len_r  <= '0;
        halt_r <= 1'b1;
      end else if (cmd.store) begin
        len_r <= len_r + LEN_W'(1);
      end else if (cmd.line_done) begin
        len_r <= '0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= load_byte;
      out_last_r <= load_last;
    end
    if (cmp) begin
      win_r <= win_nxt;
    end
    if (cmd.search_init) begin
      pat_rev_r <= pat_rev_nxt;
    end
    if (cmd.search_init || cmd.pass_reset) begin
      pos_r  <= '0;
      skip_r <= '0;
    end else if (cmp || cmd.line_out) begin
      pos_r <= pos_r + LEN_W'(1);
      if (cmp) begin
        if (hit) begin
          skip_r <= plen - PLEN_W'(1);
        end else if (skip_r != '0) begin
          skip_r <= skip_r - PLEN_W'(1);
        end
      end
    end
    if (cmd.search_init) begin
      mcount_r <= '0;
    end else if (cmd.cmp_count && hit) begin
      mcount_r <= mcount_r + LEN_W'(1);
    end
    if (cmd.pass_reset) begin
      occ_r <= '0;
    end else if (cmd.cmp_emit && hit) begin
      occ_r <= occ_r + LEN_W'(1);
    end
    if (cmd.cmp_emit && hit) begin
      k_r <= '0;
    end else if (cmd.emit_pat) begin
      k_r <= k_r + PLEN_W'(1);
    end
  end

  assign in_req.ready     = cmd.in_ready;
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.out_byte = out_byte_r;
  assign out_rsp.last     = out_last_r;

  always_comb begin
    st             = '0;
    st.in_valid    = in_req.valid;
    st.in_eof      = in_req.kind;
    st.in_nl       = (in_req.in_byte == lsf_pkg::NEWLINE_BYTE);
    st.halt        = halt_r;
    st.full        = (32'(len_r) + 2 >= lsf_pkg::LINE_BYTES);
    st.len_zero    = (len_r == '0);
    st.hit         = hit;
    st.last_pos    = (pos_r + LEN_W'(1) == len_r);
    st.pos_end     = (pos_r == len_r);
    st.mcount_zero = (mcount_r == '0);
    st.only        = only_r;
    st.out_free    = out_free;
    st.emit_done   = (k_r == plen);
  end

  `LSF_ASSERT_IMP(a_len_cap, clk, rst_n, 1'b1, 32'(len_r) <= lsf_pkg::LINE_BYTES - 2)
  `LSF_ASSERT_IMP(a_halt_empty, clk, rst_n, halt_r, len_r == '0)
  `LSF_ASSERT_IMP(a_load_free, clk, rst_n, load, out_free)
  `LSF_ASSERT_NXT(a_store_grows, clk, rst_n, cmd.store, len_r == $past(len_r) + LEN_W'(1))

endmodule

// ----- src/line_substring_filter.sv -----
// Fixed-string line filter.
// in_req carries one request per text byte (kind 0) or an end of file
// (kind 1); out_rsp returns emitted bytes, last marking the final byte for
// the request that caused them. cfg_we/cfg_index/cfg_wdata write the
// pattern bytes, pattern length and mode; write only while idle.
// Data bytes and end of file are taken one per cycle and emit nothing.
// A newline ending a line starts a pass that counts pattern occurrences,
// one pattern compare per line byte, each after a read of the line RAM.
// If any were counted, line mode then emits the line, one byte per RAM
// read, and a newline; only-matching mode rescans the line and emits the
// pattern and a newline per occurrence. in_req.ready is low meanwhile.
// The result sits in an output register: the next request is taken while
// a finished byte waits, and a stalled receiver holds the datapath.
// Reset clears the line, the halt flag and the output register, and sets
// the pattern to one zero byte in line mode. The line RAM is not cleared.
module line_substring_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  lsf_in_if.sink                             in_req,
  lsf_out_if.source                          out_rsp,
  input  logic                               cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  lsf_pkg::lsf_cmd_t cmd;
  lsf_pkg::lsf_sts_t st;

  lsf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  lsf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
